### rtl/core/tabulated_pair_force_kernel_top_macros.svh
// Assertion macros shared by the pair force kernel RTL.
`ifndef TABULATED_PAIR_FORCE_KERNEL_TOP_MACROS_SVH
`define TABULATED_PAIR_FORCE_KERNEL_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TPFK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TPFK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/tpfk_pkg.sv
// Shared types and constants of the tabulated pair force kernel.
package tpfk_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int NUM_KINDS   = 3;
  localparam int BIN_W       = $clog2(TABLE_DEPTH);
  localparam int MEM_DEPTH   = NUM_KINDS * TABLE_DEPTH;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  localparam logic CFG_RANGE_SQ = 1'b0;
  localparam logic CFG_INV_STEP = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD_ENERGY = 2'd0,
    ACT_LOAD_FORCE  = 2'd1,
    ACT_COMPUTE     = 2'd2
  } action_e;

  // Item fields carried alongside the arithmetic
  typedef struct packed {
    action_e            act;
    logic [1:0]         kind;
    logic [9:0]         idx;
    logic [31:0]        val;
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_y;
    logic signed [31:0] sep_z;
    logic [31:0]        sq;
    logic               inr;
  } side_t;

endpackage

### rtl/core/tpfk_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage.
module tpfk_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  tpfk_pkg::side_t side_i,
  input  logic [63:0]     sum_i,
  output logic            vld_o,
  output tpfk_pkg::side_t side_o,
  output logic [31:0]     root_o
);
  import tpfk_pkg::*;

  localparam int STAGES = 32;

  logic        vld_q  [STAGES];
  side_t       side_q [STAGES];
  logic [63:0] rem_q  [STAGES];
  logic [63:0] res_q  [STAGES];
  logic [63:0] rem_d  [STAGES];
  logic [63:0] res_d  [STAGES];

  // One digit step per stage, bit weight falls by four each stage
  always_comb begin
    logic [63:0] rem_s;
    logic [63:0] res_s;
    logic [63:0] bit_w;
    logic [63:0] trial;
    for (int k = 0; k < STAGES; k++) begin
      rem_s = (k == 0) ? sum_i : rem_q[(k == 0) ? 0 : k - 1];
      res_s = (k == 0) ? 64'd0 : res_q[(k == 0) ? 0 : k - 1];
      bit_w = 64'd1 << (62 - 2 * k);
      trial = res_s + bit_w;
      if (rem_s >= trial) begin
        rem_d[k] = rem_s - trial;
        res_d[k] = (res_s >> 1) + bit_w;
      end else begin
        rem_d[k] = rem_s;
        res_d[k] = res_s >> 1;
      end
    end
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < STAGES; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < STAGES; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        res_q[k] <= res_d[k];
      end
    end
  end

  assign vld_o  = vld_q[STAGES-1];
  assign side_o = side_q[STAGES-1];
  assign root_o = res_q[STAGES-1][31:0];

endmodule

### rtl/core/tabulated_pair_force_kernel_top.sv
// Top level of the tabulated pair force kernel: pipeline and table memories.
//
//  Channel  | Direction | Carries
//  s_axis   | in        | tuser: action, table_kind; tdata: index, value, six coordinates
//  m_axis   | out       | tuser: in_range; tdata: force x/y/z, energy, squared distance
//  cfg      | in        | register index and 32-bit write data, always ready
//
// One item per cycle while no held result stalls the pipe.
// Stages: capture, square, sum, the 32-stage square root, bin scale, table read, force multiply, output.
// Tables live in two 3*TABLE_DEPTH x 32 memories; no clearing pass after reset.
// A stalled result freezes the whole pipeline, so s_axis_tready is low only while a result waits on m_axis_tready.
`include "tabulated_pair_force_kernel_top_macros.svh"

module tabulated_pair_force_kernel_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] action, [3:2] table_kind
  input  logic [3:0]   s_axis_tuser,
  // [9:0] table_index, [41:10] table_value, [73:42] first_x, [105:74] first_y,
  // [137:106] first_z, [169:138] second_x, [201:170] second_y, [233:202] second_z
  input  logic [239:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] in_range
  output logic         m_axis_tuser,
  // [47:0] force_x, [95:48] force_y, [143:96] force_z, [175:144] energy,
  // [207:176] squared_distance
  output logic [207:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import tpfk_pkg::*;

  logic        adv;
  logic [31:0] range_sq_q, inv_step_q;

  logic               p0_vld_q;
  side_t              p0_side_q;
  logic               p1_vld_q;
  side_t              p1_side_q;
  logic [63:0]        p1_sqx_q, p1_sqy_q, p1_sqz_q;
  logic               p2_vld_q;
  side_t              p2_side_q;
  logic [63:0]        p2_sum_q;
  side_t              rt_side_in;
  logic               rt_vld;
  side_t              rt_side;
  logic [31:0]        rt_root;
  logic               p3_vld_q;
  side_t              p3_side_q;
  logic [63:0]        p3_prod_q;
  logic               p4_vld_q;
  side_t              p4_side_q;
  logic               p4_hit_q;
  logic [31:0]        e_rd_q, f_rd_q;
  logic               p5_vld_q;
  side_t              p5_side_q;
  logic               p5_hit_q;
  logic [31:0]        p5_e_q;
  logic signed [63:0] p5_fx_q, p5_fy_q, p5_fz_q;
  logic               out_vld_q;
  logic               out_inr_q;
  logic [207:0]       out_data_q;

  logic [31:0] energy_mem [MEM_DEPTH];
  logic [31:0] force_mem  [MEM_DEPTH];

  // Stall the whole pipe only when the result register is held
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_sq_q <= 32'd0;
      inv_step_q <= 32'd65536;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_RANGE_SQ) range_sq_q <= cfg_data_i;
      if (cfg_index_i == CFG_INV_STEP) inv_step_q <= cfg_data_i;
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      p5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      p0_vld_q  <= s_axis_tvalid;
      p1_vld_q  <= p0_vld_q;
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= rt_vld;
      p4_vld_q  <= p3_vld_q;
      p5_vld_q  <= p4_vld_q;
      out_vld_q <= p5_vld_q;
    end
  end

  // Capture the item and form the separations, first point minus second
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_side_q.act   <= action_e'(s_axis_tuser[1:0]);
      p0_side_q.kind  <= s_axis_tuser[3:2];
      p0_side_q.idx   <= s_axis_tdata[9:0];
      p0_side_q.val   <= s_axis_tdata[41:10];
      p0_side_q.sep_x <= s_axis_tdata[73:42]   - s_axis_tdata[169:138];
      p0_side_q.sep_y <= s_axis_tdata[105:74]  - s_axis_tdata[201:170];
      p0_side_q.sep_z <= s_axis_tdata[137:106] - s_axis_tdata[233:202];
      p0_side_q.sq    <= 32'd0;
      p0_side_q.inr   <= 1'b0;
    end
  end

  // Square each axis, then sum
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_side_q <= p0_side_q;
      p1_sqx_q  <= $signed(p0_side_q.sep_x) * $signed(p0_side_q.sep_x);
      p1_sqy_q  <= $signed(p0_side_q.sep_y) * $signed(p0_side_q.sep_y);
      p1_sqz_q  <= $signed(p0_side_q.sep_z) * $signed(p0_side_q.sep_z);
      p2_side_q <= p1_side_q;
      p2_sum_q  <= p1_sqx_q + p1_sqy_q + p1_sqz_q;
    end
  end

  // Attach squared distance and range flag before the root
  always_comb begin
    rt_side_in     = p2_side_q;
    rt_side_in.sq  = p2_sum_q[63:32];
    rt_side_in.inr = p2_sum_q[63:32] < range_sq_q;
  end

  tpfk_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (p2_vld_q),
    .side_i (rt_side_in),
    .sum_i  (p2_sum_q),
    .vld_o  (rt_vld),
    .side_o (rt_side),
    .root_o (rt_root)
  );

  // Scale the distance into table bins
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_side_q <= rt_side;
      p3_prod_q <= rt_root * inv_step_q;
    end
  end

  // Table access: loads write and computes read at the same stage, in order
  logic [BIN_W-1:0]  bin;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              kind_ok, hit, wr_ok;

  always_comb begin
    if ({1'b0, p3_prod_q[63:48]} > 17'(TABLE_DEPTH - 1)) bin = BIN_W'(TABLE_DEPTH - 1);
    else bin = BIN_W'(p3_prod_q[63:48]);
    kind_ok = p3_side_q.kind < 2'(NUM_KINDS);
    hit     = p3_side_q.act == ACT_COMPUTE && p3_side_q.inr && kind_ok;
    wr_ok   = kind_ok && (17'(p3_side_q.idx) < 17'(TABLE_DEPTH));
    rd_addr = ADDR_W'(p3_side_q.kind) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(bin);
    wr_addr = ADDR_W'(p3_side_q.kind) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(p3_side_q.idx);
  end

  always_ff @(posedge clk_i) begin
    if (adv && p3_vld_q && wr_ok && p3_side_q.act == ACT_LOAD_ENERGY) begin
      energy_mem[wr_addr] <= p3_side_q.val;
    end
    if (adv && p3_vld_q && wr_ok && p3_side_q.act == ACT_LOAD_FORCE) begin
      force_mem[wr_addr] <= p3_side_q.val;
    end
    if (adv) begin
      e_rd_q    <= energy_mem[rd_addr];
      f_rd_q    <= force_mem[rd_addr];
      p4_side_q <= p3_side_q;
      p4_hit_q  <= hit;
    end
  end

  // Multiply force-over-r by each separation
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p5_side_q <= p4_side_q;
      p5_hit_q  <= p4_hit_q;
      p5_e_q    <= e_rd_q;
      p5_fx_q   <= $signed(f_rd_q) * $signed(p4_side_q.sep_x);
      p5_fy_q   <= $signed(f_rd_q) * $signed(p4_side_q.sep_y);
      p5_fz_q   <= $signed(f_rd_q) * $signed(p4_side_q.sep_z);
    end
  end

  // Negate, drop 16 fraction bits and mask what does not apply
  logic signed [63:0] nx, ny, nz;
  logic               is_cmp;

  always_comb begin
    nx     = -p5_fx_q;
    ny     = -p5_fy_q;
    nz     = -p5_fz_q;
    is_cmp = p5_side_q.act == ACT_COMPUTE;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q[47:0]    <= p5_hit_q ? nx[63:16] : 48'd0;
      out_data_q[95:48]   <= p5_hit_q ? ny[63:16] : 48'd0;
      out_data_q[143:96]  <= p5_hit_q ? nz[63:16] : 48'd0;
      out_data_q[175:144] <= p5_hit_q ? p5_e_q : 32'd0;
      out_data_q[207:176] <= is_cmp ? p5_side_q.sq : 32'd0;
      out_inr_q           <= is_cmp && p5_side_q.inr;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_inr_q;
  assign m_axis_tdata  = out_data_q;

  `TPFK_ASSERT_IMPL(a_out_of_range_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[175:0] == 176'd0, "force or energy given for an out-of-range pair")
  `TPFK_ASSERT_IMPL(a_in_range_below_cut, m_axis_tvalid && m_axis_tuser, m_axis_tdata[207:176] < range_sq_q, "in-range flag set at or beyond cutoff")
  `TPFK_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with no result waiting")

endmodule
